// ===== rtl/core/slcfb_pkg.sv =====
// shared types, constants and crc helper for the sync/length/crc frame builder
`default_nettype none

package slcfb_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int PLEN_W      = $clog2(MAX_PAYLOAD + 1);

    localparam logic [15:0] MAX_PAYLOAD_16 = 16'(MAX_PAYLOAD);
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  SYNC_RESET     = 8'hAA;
    localparam logic [15:0] SEED_RESET     = 16'hFFFF;

    // configuration register indexes
    localparam int          CFG_IDX_W = 1;
    localparam int          CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 1'b1;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0]  packet_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [31:0] frames_sent;
    } out_word_t;

    typedef struct packed {
        logic              is_start;
        logic              last;
        logic [7:0]        sync;
        logic [7:0]        ptype;
        logic [PLEN_W-1:0] len;
        logic [7:0]        data;
        logic [15:0]       seed;
    } cmd_t;

    // one byte of crc-16, poly 0x1021, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slcfb_front.sv =====
// input side: config registers, packet tracking and command generation
`default_nettype none

module slcfb_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [slcfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slcfb_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire slcfb_pkg::in_word_t            s_data,
    input  wire logic                           q_full,
    output logic                                q_push,
    output slcfb_pkg::cmd_t                     q_cmd
);

    logic [7:0]                    sync_reg;
    logic [15:0]                   seed_reg;
    logic [15:0]                   items_left_reg, items_left_next;
    logic [slcfb_pkg::PLEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic                          accept;
    logic [slcfb_pkg::PLEN_W-1:0]  clamp_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign clamp_len = (s_data.payload_length > slcfb_pkg::MAX_PAYLOAD_16) ?
                       slcfb_pkg::PLEN_W'(slcfb_pkg::MAX_PAYLOAD) :
                       s_data.payload_length[slcfb_pkg::PLEN_W-1:0];

    always_comb begin
        items_left_next = items_left_reg;
        bytes_left_next = bytes_left_reg;
        q_push          = 1'b0;
        q_cmd.is_start  = 1'b0;
        q_cmd.last      = 1'b0;
        q_cmd.sync      = sync_reg;
        q_cmd.ptype     = s_data.packet_type;
        q_cmd.len       = clamp_len;
        q_cmd.data      = s_data.data_byte;
        q_cmd.seed      = seed_reg;
        if (accept) begin
            if (items_left_reg == 16'd0) begin
                // first word of a packet
                q_push          = 1'b1;
                q_cmd.is_start  = 1'b1;
                q_cmd.last      = (clamp_len == slcfb_pkg::PLEN_W'(1));
                items_left_next = (s_data.payload_length == 16'd0) ? 16'd0 :
                                  s_data.payload_length - 16'd1;
                bytes_left_next = (clamp_len == '0) ? '0 :
                                  clamp_len - slcfb_pkg::PLEN_W'(1);
            end else begin
                items_left_next = items_left_reg - 16'd1;
                // surplus words past the clamped length are dropped
                if (bytes_left_reg != '0) begin
                    q_push          = 1'b1;
                    q_cmd.last      = (bytes_left_reg == slcfb_pkg::PLEN_W'(1));
                    bytes_left_next = bytes_left_reg - slcfb_pkg::PLEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg       <= slcfb_pkg::SYNC_RESET;
            seed_reg       <= slcfb_pkg::SEED_RESET;
            items_left_reg <= '0;
            bytes_left_reg <= '0;
        end else begin
            items_left_reg <= items_left_next;
            bytes_left_reg <= bytes_left_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    slcfb_pkg::CFG_SYNC_VALUE: sync_reg <= cfg_wdata[7:0];
                    slcfb_pkg::CFG_CRC_SEED:   seed_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/slcfb_queue.sv =====
// small first-word-fall-through command queue
`default_nettype none

module slcfb_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire slcfb_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output slcfb_pkg::cmd_t      head_cmd
);

    slcfb_pkg::cmd_t                 mem [slcfb_pkg::QDEPTH];
    logic [slcfb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [slcfb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [slcfb_pkg::QPTR_W:0]      count_reg;
    logic                            do_push, do_pop;

    assign full      = (count_reg == (slcfb_pkg::QPTR_W + 1)'(slcfb_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + slcfb_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + slcfb_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (slcfb_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (slcfb_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/slcfb_back.sv =====
// output side: byte sequencer, running crc and frame counter
`default_nettype none

module slcfb_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_not_empty,
    input  wire slcfb_pkg::cmd_t q_cmd,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output slcfb_pkg::out_word_t m_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TYPE = 3'd1;
    localparam logic [2:0] S_LENL = 3'd2;
    localparam logic [2:0] S_LENH = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_CRCL = 3'd5;
    localparam logic [2:0] S_CRCH = 3'd6;

    logic [2:0]           state_reg, state_next;
    slcfb_pkg::cmd_t      cmd_reg, cmd_next;
    logic [15:0]          crc_reg, crc_next;
    logic [31:0]          cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    slcfb_pkg::out_word_t word_reg, word_next;

    logic                 adv;
    logic                 ld;
    logic [7:0]           ld_byte;
    logic                 ld_end;
    logic                 crc_upd;
    logic [15:0]          crc_base;
    logic [15:0]          len16;

    assign adv     = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = word_reg;
    assign len16   = 16'(cmd_reg.len);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        crc_next     = crc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        word_next    = word_reg;
        q_pop        = 1'b0;
        ld           = 1'b0;
        ld_byte      = 8'h00;
        ld_end       = 1'b0;
        crc_upd      = 1'b0;
        crc_base     = crc_reg;
        if (adv) begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        q_pop    = 1'b1;
                        cmd_next = q_cmd;
                        ld       = 1'b1;
                        crc_upd  = 1'b1;
                        if (q_cmd.is_start) begin
                            ld_byte    = q_cmd.sync;
                            crc_base   = q_cmd.seed;
                            state_next = S_TYPE;
                        end else begin
                            ld_byte    = q_cmd.data;
                            state_next = q_cmd.last ? S_CRCL : S_IDLE;
                        end
                    end
                end
                S_TYPE: begin
                    ld         = 1'b1;
                    crc_upd    = 1'b1;
                    ld_byte    = cmd_reg.ptype;
                    state_next = S_LENL;
                end
                S_LENL: begin
                    ld         = 1'b1;
                    crc_upd    = 1'b1;
                    ld_byte    = len16[7:0];
                    state_next = S_LENH;
                end
                S_LENH: begin
                    ld         = 1'b1;
                    crc_upd    = 1'b1;
                    ld_byte    = len16[15:8];
                    state_next = (cmd_reg.len == '0) ? S_CRCL : S_DATA;
                end
                S_DATA: begin
                    ld         = 1'b1;
                    crc_upd    = 1'b1;
                    ld_byte    = cmd_reg.data;
                    state_next = cmd_reg.last ? S_CRCL : S_IDLE;
                end
                S_CRCL: begin
                    ld         = 1'b1;
                    ld_byte    = crc_reg[7:0];
                    state_next = S_CRCH;
                end
                S_CRCH: begin
                    ld         = 1'b1;
                    ld_byte    = crc_reg[15:8];
                    ld_end     = 1'b1;
                    cnt_next   = cnt_reg + 32'd1;
                    state_next = S_IDLE;
                end
                default: state_next = S_IDLE;
            endcase
        end
        if (ld) begin
            m_valid_next          = 1'b1;
            word_next.out_byte    = ld_byte;
            word_next.frame_end   = ld_end;
            word_next.frames_sent = cnt_reg + 32'd1;
        end
        if (crc_upd) begin
            crc_next = slcfb_pkg::crc16_byte(crc_base, ld_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            crc_reg     <= slcfb_pkg::SEED_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            crc_reg     <= crc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sync_len_crc_frame_builder.sv =====
// top level of the sync/type/length/payload/crc-16 frame builder
//
//  port group   dir  handshake          word
//  s_*          in   s_valid/s_ready    in_word_t: packet_type, payload_length, data_byte
//  m_*          out  m_valid/m_ready    out_word_t: out_byte, frame_end, frames_sent
//  cfg_*        in   cfg_we only        cfg_index, cfg_wdata
//
// one byte goes out per cycle unless stalled; a payload word yields 1 byte, 3 when it closes the frame
// a packet's first word yields 5 bytes, 6 for zero length, 7 when it also ends the frame
// a 4-entry command queue holds the front off only when the byte sequencer falls behind
// reset is synchronous and active low; there is no clearing pass
// m_ready low stalls the output register, then the queue, then s_ready
`default_nettype none

module sync_len_crc_frame_builder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [slcfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slcfb_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire slcfb_pkg::in_word_t             s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output slcfb_pkg::out_word_t                 m_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_not_empty;
    slcfb_pkg::cmd_t push_cmd;
    slcfb_pkg::cmd_t head_cmd;

    slcfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    slcfb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    slcfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/sync_len_crc_frame_builder_test.sv =====
// self-checking testbench for the sync/type/length/payload/crc-16 frame builder
`timescale 1ns / 100ps

module sync_len_crc_frame_builder_test;

    localparam logic [3:0] NOT_TYPED = 4'hF;

    // one directed input word and the number of frame words it must yield
    typedef struct packed {
        slcfb_pkg::in_word_t word;
        logic [3:0]          yields;
    } plan_row_t;

    localparam plan_row_t PLAN [18] = '{
        {8'h00, 16'h0000, 8'hFF, 4'd6},       // zero length, data ignored
        {8'hFF, 16'h0000, 8'h00, 4'd6},
        {8'hFF, 16'h0001, 8'hFF, 4'd7},       // one byte closes the frame at once
        {8'h00, 16'h0001, 8'h00, 4'd7},
        {8'hA5, 16'h0002, 8'h00, 4'd5},
        {8'h00, 16'hFFFF, 8'hFF, NOT_TYPED},  // length field ignored after first word
        {8'h3C, 16'h0003, 8'h80, 4'd5},
        {8'hFF, 16'h0000, 8'h01, NOT_TYPED},
        {8'h00, 16'h8000, 8'h7F, NOT_TYPED},
        {8'h81, 16'h0004, 8'h55, 4'd5},
        {8'h7E, 16'h1234, 8'hAA, NOT_TYPED},
        {8'h00, 16'hFFFF, 8'h00, NOT_TYPED},
        {8'hFF, 16'h7FFF, 8'hFF, NOT_TYPED},
        {8'hC3, 16'h0005, 8'hFE, 4'd5},
        {8'h5A, 16'h00FF, 8'h01, NOT_TYPED},
        {8'h00, 16'hFF00, 8'h80, NOT_TYPED},
        {8'hFF, 16'h0101, 8'h7F, NOT_TYPED},
        {8'h11, 16'hAAAA, 8'h00, NOT_TYPED}
    };

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [slcfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [slcfb_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    slcfb_pkg::in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    slcfb_pkg::out_word_t m_data;

    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int mismatch_count = 0;
    int framed_items  = 0;

    // predictor state
    logic [7:0]  cfg_sync;
    logic [15:0] cfg_seed;
    logic [15:0] crc_run;
    logic [15:0] payload_left;
    logic [15:0] words_left;
    logic [31:0] frame_cnt;
    slcfb_pkg::out_word_t frame_bytes_due [$];

    sync_len_crc_frame_builder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            r = {r[14:0], 1'b0} ^ ((r[15] ^ b[i]) ? slcfb_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        slcfb_pkg::out_word_t w;
        w.out_byte    = b;
        w.frame_end   = last;
        w.frames_sent = frame_cnt + 32'd1;
        frame_bytes_due.push_back(w);
    endfunction

    function automatic void queue_crc();
        queue_byte(crc_run[7:0], 1'b0);
        queue_byte(crc_run[15:8], 1'b1);
        frame_cnt = frame_cnt + 32'd1;
    endfunction

    function automatic void queue_payload(input logic [7:0] b);
        crc_run = crc_next(crc_run, b);
        queue_byte(b, 1'b0);
        payload_left = payload_left - 16'd1;
        if (payload_left == 16'd0) begin
            queue_crc();
        end
    endfunction

    // returns how many frame words the accepted input word adds
    function automatic int predict_word(input slcfb_pkg::in_word_t w);
        logic [15:0] len;
        logic [7:0]  hdr [4];
        int          queued;
        queued = frame_bytes_due.size();
        if (words_left == 16'd0) begin
            len = (w.payload_length > slcfb_pkg::MAX_PAYLOAD_16) ?
                  slcfb_pkg::MAX_PAYLOAD_16 : w.payload_length;
            hdr[0] = cfg_sync;
            hdr[1] = w.packet_type;
            hdr[2] = len[7:0];
            hdr[3] = len[15:8];
            words_left = ((w.payload_length == 16'd0) ? 16'd1 : w.payload_length) - 16'd1;
            crc_run = cfg_seed;
            for (int i = 0; i < 4; i++) begin
                crc_run = crc_next(crc_run, hdr[i]);
                queue_byte(hdr[i], 1'b0);
            end
            payload_left = len;
            if (len == 16'd0) begin
                queue_crc();
            end else begin
                queue_payload(w.data_byte);
            end
        end else begin
            words_left = words_left - 16'd1;
            // surplus words past the clamped length are swallowed
            if (payload_left != 16'd0) begin
                queue_payload(w.data_byte);
            end
        end
        return frame_bytes_due.size() - queued;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_word(input slcfb_pkg::out_word_t got);
        slcfb_pkg::out_word_t want;
        if (frame_bytes_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected word byte=%h end=%b count=%0d",
                                    got.out_byte, got.frame_end, got.frames_sent));
            return;
        end
        want = frame_bytes_due.pop_front();
        if (got.out_byte !== want.out_byte) begin
            flag_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        end
        if (got.frame_end !== want.frame_end) begin
            flag_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
        end
        if (got.frames_sent !== want.frames_sent) begin
            flag_mismatch($sformatf("frames_sent %0d, want %0d",
                                    got.frames_sent, want.frames_sent));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_word(m_data);
        end
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // valid stays high from one word to the next unless an idle cycle falls between
    task automatic push_word(input slcfb_pkg::in_word_t w, output int produced);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        produced = predict_word(w);
    endtask

    task automatic send_packet(input logic [7:0] kind, input logic [15:0] len);
        slcfb_pkg::in_word_t w;
        int       produced;
        int       span;
        span = (len == 16'd0) ? 1 : int'(len);
        for (int i = 0; i < span; i++) begin
            w.packet_type    = (i == 0) ? kind : 8'($urandom);
            w.payload_length = (i == 0) ? len : 16'($urandom);
            w.data_byte      = 8'($urandom);
            push_word(w, produced);
            if (produced > 0) begin
                framed_items++;
            end
        end
    endtask

    task automatic random_traffic(input int quota);
        int          pick;
        logic [15:0] len;
        framed_items = 0;
        while (framed_items < quota) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                len = 16'd0;
            end else if (pick < 25) begin
                len = 16'd1;
            end else if (pick < 88) begin
                len = 16'($urandom_range(12, 2));
            end else begin
                len = 16'($urandom_range(24, 13));
            end
            send_packet(8'($urandom), len);
        end
    endtask

    // drop valid, let every expected word drain, then give the back end time to go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (32) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [slcfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == slcfb_pkg::CFG_SYNC_VALUE) begin
            cfg_sync = val[7:0];
        end else if (idx == slcfb_pkg::CFG_CRC_SEED) begin
            cfg_seed = val;
        end
    endtask

    initial begin
        int produced;
        cfg_sync     = slcfb_pkg::SYNC_RESET;
        cfg_seed     = slcfb_pkg::SEED_RESET;
        crc_run      = slcfb_pkg::SEED_RESET;
        payload_left = 16'd0;
        words_left   = 16'd0;
        frame_cnt    = 32'd0;
        src_idle_pct = 37;
        snk_idle_pct = 86;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PLAN[i]) begin
            push_word(PLAN[i].word, produced);
            if (PLAN[i].yields != NOT_TYPED && produced != int'(PLAN[i].yields)) begin
                flag_mismatch($sformatf("row %0d: %0d words predicted, table gives %0d",
                                        i, produced, PLAN[i].yields));
            end
        end
        settle();

        // low extremes; upper bits of the sync write must be ignored
        cfg_write(slcfb_pkg::CFG_SYNC_VALUE, {8'($urandom), 8'h00});
        cfg_write(slcfb_pkg::CFG_CRC_SEED, 16'h0000);
        cfg_we <= 1'b0;
        random_traffic(25);
        settle();

        src_idle_pct = 86;
        snk_idle_pct = 37;
        cfg_write(slcfb_pkg::CFG_SYNC_VALUE, {8'($urandom), 8'hFF});
        cfg_write(slcfb_pkg::CFG_CRC_SEED, 16'hFFFF);
        cfg_we <= 1'b0;
        random_traffic(25);
        settle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        cfg_write(slcfb_pkg::CFG_SYNC_VALUE, 16'($urandom_range(254, 1)));
        cfg_write(slcfb_pkg::CFG_CRC_SEED, 16'($urandom_range(65534, 1)));
        cfg_we <= 1'b0;
        // one over the clamp: a full-size frame and one surplus word
        send_packet(8'($urandom), slcfb_pkg::MAX_PAYLOAD_16 + 16'd1);
        random_traffic(10);
        settle();

        if (mismatch_count == 0) begin
            $display("sync_len_crc_frame_builder_test passed");
        end else begin
            $display("sync_len_crc_frame_builder_test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("sync_len_crc_frame_builder_test failed");
        $finish;
    end

endmodule
